[rtl/core/ctu_pkg.sv]
package ctu_pkg;

   localparam int FACE_IDX_W      = 3;
   localparam int TEXEL_W         = 12;
   localparam int EDGE_LEN_W      = 13;
   localparam int MAX_EDGE_LEN    = 4096;
   localparam int COORD_FRAC_BITS = 16;
   localparam int COORD_W         = COORD_FRAC_BITS + 1;

   // direction component before scaling: +-edge length or 2*texel+1-edge length
   localparam int COMP_W     = EDGE_LEN_W + 1;
   localparam int DIR_SHIFT  = 16;
   localparam int SUMSQ_W    = 2 * COMP_W;
   localparam int RAD_IN_W   = SUMSQ_W + 2 * DIR_SHIFT;
   localparam int ROOT_W     = RAD_IN_W / 2;

   localparam int CORDIC_W     = 34;
   localparam int ANG_W        = 34;
   localparam int CORDIC_STEPS = 28;
   localparam int LANE_COUNT   = 2;
   localparam int LANE_U       = 0;
   localparam int LANE_V       = 1;

   localparam int ANGLE_BITS = 32;
   localparam int EXT_W      = ANG_W + 2;

   localparam logic [EDGE_LEN_W-1:0] EDGE_LEN_RESET = EDGE_LEN_W'(512);

   localparam logic [FACE_IDX_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_IDX_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_IDX_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_IDX_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_IDX_W-1:0] FACE_POS_Z = 3'd4;

   typedef logic signed [COMP_W-1:0]   comp_type;
   typedef logic signed [CORDIC_W-1:0] cvec_type;
   typedef logic signed [ANG_W-1:0]    ang_type;
   typedef logic signed [EXT_W-1:0]    ext_type;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
   } dir_type;

   typedef struct packed {
      cvec_type ax;
      cvec_type ay;
      ang_type  acc;
   } crd_type;

   localparam ang_type HALF_TURN     = ang_type'(64'sd2147483648);
   localparam ext_type HALF_TURN_EXT = ext_type'(64'sd2147483648);
   localparam ext_type FULL_TURN_EXT = ext_type'(64'sd4294967296);
   localparam logic [EXT_W-1:0] ROUND_ADD =
      EXT_W'(1) << (ANGLE_BITS - 1 - COORD_FRAC_BITS);
   localparam logic [EXT_W-1:0] COORD_ONE = EXT_W'(1) << COORD_FRAC_BITS;

   // atan(2^-i) in units of 2^-32 turn
   function automatic ang_type atan_turn(input int i);
      ang_type r;
      case (i)
         0:  r = ang_type'(536870912);
         1:  r = ang_type'(316933406);
         2:  r = ang_type'(167458907);
         3:  r = ang_type'(85004756);
         4:  r = ang_type'(42667331);
         5:  r = ang_type'(21354465);
         6:  r = ang_type'(10679838);
         7:  r = ang_type'(5340245);
         8:  r = ang_type'(2670163);
         9:  r = ang_type'(1335087);
         10: r = ang_type'(667544);
         11: r = ang_type'(333772);
         12: r = ang_type'(166886);
         13: r = ang_type'(83443);
         14: r = ang_type'(41722);
         15: r = ang_type'(20861);
         16: r = ang_type'(10430);
         17: r = ang_type'(5215);
         18: r = ang_type'(2608);
         19: r = ang_type'(1304);
         20: r = ang_type'(652);
         21: r = ang_type'(326);
         22: r = ang_type'(163);
         23: r = ang_type'(81);
         24: r = ang_type'(41);
         25: r = ang_type'(20);
         26: r = ang_type'(10);
         27: r = ang_type'(5);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/ctu_if.sv]
interface ctu_req_if;
   logic                             valid;
   logic                             ready;
   logic [ctu_pkg::FACE_IDX_W-1:0]   face_index;
   logic [ctu_pkg::TEXEL_W-1:0]      texel_col;
   logic [ctu_pkg::TEXEL_W-1:0]      texel_row;

   modport source (output valid, output face_index, output texel_col, output texel_row,
                   input ready);
   modport sink   (input valid, input face_index, input texel_col, input texel_row,
                   output ready);
endinterface

interface ctu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ctu_pkg::COORD_W-1:0]   coord_u;
   logic [ctu_pkg::COORD_W-1:0]   coord_v;

   modport source (output valid, output coord_u, output coord_v, input ready);
   modport sink   (input valid, input coord_u, input coord_v, output ready);
endinterface

[rtl/core/ctu_dir.sv]
module ctu_dir (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_vld,
   input  logic [ctu_pkg::FACE_IDX_W-1:0]    face_index,
   input  logic [ctu_pkg::TEXEL_W-1:0]       texel_col,
   input  logic [ctu_pkg::TEXEL_W-1:0]       texel_row,
   input  logic [ctu_pkg::EDGE_LEN_W-1:0]    edge_len,
   output logic                              out_vld,
   output ctu_pkg::dir_type                  out_dir,
   output logic [ctu_pkg::SUMSQ_W-1:0]       out_sumsq
);

   logic signed [ctu_pkg::COMP_W:0] col_ext, row_ext, n_ext;
   ctu_pkg::comp_type s_val, t_val, n_val;
   ctu_pkg::dir_type  dir_in;
   ctu_pkg::dir_type  dir_a_ff;
   logic              vld_a_ff;
   logic signed [2*ctu_pkg::COMP_W-1:0] xsq, zsq;
   logic [ctu_pkg::SUMSQ_W-1:0] sumsq_in;
   ctu_pkg::dir_type  dir_b_ff;
   logic [ctu_pkg::SUMSQ_W-1:0] sumsq_ff;
   logic              vld_b_ff;

   assign col_ext = $signed({2'b00, texel_col, 1'b1});
   assign row_ext = $signed({2'b00, texel_row, 1'b1});
   assign n_ext   = $signed({2'b00, edge_len});
   assign s_val   = ctu_pkg::comp_type'(col_ext - n_ext);
   assign t_val   = ctu_pkg::comp_type'(row_ext - n_ext);
   assign n_val   = ctu_pkg::comp_type'(n_ext);

   // faces six and seven fall to -Z
   always_comb begin
      unique case (face_index)
         ctu_pkg::FACE_POS_X: dir_in = '{x: n_val,  y: -t_val, z: -s_val};
         ctu_pkg::FACE_NEG_X: dir_in = '{x: -n_val, y: -t_val, z: s_val};
         ctu_pkg::FACE_POS_Y: dir_in = '{x: s_val,  y: n_val,  z: t_val};
         ctu_pkg::FACE_NEG_Y: dir_in = '{x: s_val,  y: -n_val, z: -t_val};
         ctu_pkg::FACE_POS_Z: dir_in = '{x: s_val,  y: -t_val, z: n_val};
         default:             dir_in = '{x: -s_val, y: -t_val, z: -n_val};
      endcase
   end

   assign xsq      = dir_a_ff.x * dir_a_ff.x;
   assign zsq      = dir_a_ff.z * dir_a_ff.z;
   assign sumsq_in = ctu_pkg::SUMSQ_W'(unsigned'(xsq)) + ctu_pkg::SUMSQ_W'(unsigned'(zsq));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= in_vld;
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dir_a_ff <= dir_in;
         dir_b_ff <= dir_a_ff;
         sumsq_ff <= sumsq_in;
      end
   end

   assign out_vld   = vld_b_ff;
   assign out_dir   = dir_b_ff;
   assign out_sumsq = sumsq_ff;

endmodule

[rtl/core/ctu_isqrt.sv]
module ctu_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_vld,
   input  logic [ctu_pkg::SUMSQ_W-1:0]   in_sumsq,
   input  ctu_pkg::dir_type              in_dir,
   output logic                          out_vld,
   output logic [ctu_pkg::ROOT_W-1:0]    out_root,
   output ctu_pkg::dir_type              out_dir
);

   logic [ctu_pkg::RAD_IN_W-1:0] rem_ff  [ctu_pkg::ROOT_W];
   logic [ctu_pkg::ROOT_W-1:0]   root_ff [ctu_pkg::ROOT_W];
   ctu_pkg::dir_type             dir_ff  [ctu_pkg::ROOT_W];
   logic [ctu_pkg::ROOT_W-1:0]   vld_ff;

   // one root bit per stage, most significant first
   for (genvar j = 0; j < ctu_pkg::ROOT_W; j++) begin : g_step
      localparam int K = ctu_pkg::ROOT_W - 1 - j;
      logic [ctu_pkg::RAD_IN_W-1:0] rem_cur;
      logic [ctu_pkg::ROOT_W-1:0]   root_cur;
      ctu_pkg::dir_type             dir_cur;
      logic                         vld_cur;
      logic [ctu_pkg::RAD_IN_W+1:0] trial;
      logic [ctu_pkg::RAD_IN_W+1:0] diff;

      if (j == 0) begin : g_first
         assign rem_cur  = {in_sumsq, (2*ctu_pkg::DIR_SHIFT)'(0)};
         assign root_cur = '0;
         assign dir_cur  = in_dir;
         assign vld_cur  = in_vld;
      end else begin : g_next
         assign rem_cur  = rem_ff[j-1];
         assign root_cur = root_ff[j-1];
         assign dir_cur  = dir_ff[j-1];
         assign vld_cur  = vld_ff[j-1];
      end

      assign trial = ((ctu_pkg::RAD_IN_W+2)'(root_cur) << (K + 1))
                   | ((ctu_pkg::RAD_IN_W+2)'(1) << (2 * K));
      assign diff  = {2'b00, rem_cur} - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dir_ff[j] <= dir_cur;
            if (!diff[ctu_pkg::RAD_IN_W+1]) begin
               rem_ff[j]  <= diff[ctu_pkg::RAD_IN_W-1:0];
               root_ff[j] <= root_cur | (ctu_pkg::ROOT_W'(1) << K);
            end else begin
               rem_ff[j]  <= rem_cur;
               root_ff[j] <= root_cur;
            end
         end
      end
   end

   assign out_vld  = vld_ff[ctu_pkg::ROOT_W-1];
   assign out_root = root_ff[ctu_pkg::ROOT_W-1];
   assign out_dir  = dir_ff[ctu_pkg::ROOT_W-1];

endmodule

[rtl/core/ctu_cordic.sv]
module ctu_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  ctu_pkg::cvec_type  u_ax,
   input  ctu_pkg::cvec_type  u_ay,
   input  ctu_pkg::cvec_type  v_ax,
   input  ctu_pkg::cvec_type  v_ay,
   output logic               out_vld,
   output ctu_pkg::ang_type   ang_u,
   output ctu_pkg::ang_type   ang_v
);

   ctu_pkg::cvec_type lane_ax [ctu_pkg::LANE_COUNT];
   ctu_pkg::cvec_type lane_ay [ctu_pkg::LANE_COUNT];
   ctu_pkg::crd_type  pre_in  [ctu_pkg::LANE_COUNT];
   ctu_pkg::crd_type  crd_ff  [ctu_pkg::CORDIC_STEPS+1][ctu_pkg::LANE_COUNT];
   logic [ctu_pkg::CORDIC_STEPS:0] vld_ff;

   assign lane_ax[ctu_pkg::LANE_U] = u_ax;
   assign lane_ay[ctu_pkg::LANE_U] = u_ay;
   assign lane_ax[ctu_pkg::LANE_V] = v_ax;
   assign lane_ay[ctu_pkg::LANE_V] = v_ay;

   // fold the left half-plane onto the right, carrying half a turn
   always_comb begin
      for (int l = 0; l < ctu_pkg::LANE_COUNT; l++) begin
         if (lane_ax[l] < 0) begin
            pre_in[l].acc = (lane_ay[l] >= 0) ? ctu_pkg::HALF_TURN : -ctu_pkg::HALF_TURN;
            pre_in[l].ax  = -lane_ax[l];
            pre_in[l].ay  = -lane_ay[l];
         end else begin
            pre_in[l].acc = '0;
            pre_in[l].ax  = lane_ax[l];
            pre_in[l].ay  = lane_ay[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         crd_ff[0] <= pre_in;
      end
   end

   for (genvar i = 0; i < ctu_pkg::CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      for (genvar l = 0; l < ctu_pkg::LANE_COUNT; l++) begin : g_lane
         ctu_pkg::crd_type  cur;
         ctu_pkg::crd_type  nxt;
         ctu_pkg::cvec_type dx, dy;

         assign cur = crd_ff[i][l];
         assign dx  = cur.ay >>> i;
         assign dy  = cur.ax >>> i;

         // rotate towards the x axis
         always_comb begin
            if (cur.ay > 0) begin
               nxt.ax  = cur.ax + dx;
               nxt.ay  = cur.ay - dy;
               nxt.acc = cur.acc + ctu_pkg::atan_turn(i);
            end else begin
               nxt.ax  = cur.ax - dx;
               nxt.ay  = cur.ay + dy;
               nxt.acc = cur.acc - ctu_pkg::atan_turn(i);
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               crd_ff[i+1][l] <= nxt;
            end
         end
      end
   end

   assign out_vld = vld_ff[ctu_pkg::CORDIC_STEPS];
   assign ang_u   = crd_ff[ctu_pkg::CORDIC_STEPS][ctu_pkg::LANE_U].acc;
   assign ang_v   = crd_ff[ctu_pkg::CORDIC_STEPS][ctu_pkg::LANE_V].acc;

endmodule

[rtl/core/ctu_coord.sv]
module ctu_coord (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  ctu_pkg::ang_type            ang_u,
   input  ctu_pkg::ang_type            ang_v,
   output logic                        out_vld,
   output logic [ctu_pkg::COORD_W-1:0] coord_u,
   output logic [ctu_pkg::COORD_W-1:0] coord_v
);

   function automatic logic [ctu_pkg::COORD_W-1:0] to_coord(input ctu_pkg::ext_type v);
      ctu_pkg::ext_type             c;
      logic [ctu_pkg::EXT_W-1:0]    r;
      c = v;
      if (c < 0) c = '0;
      if (c > ctu_pkg::FULL_TURN_EXT) c = ctu_pkg::FULL_TURN_EXT;
      r = (unsigned'(c) + ctu_pkg::ROUND_ADD) >> (ctu_pkg::ANGLE_BITS - ctu_pkg::COORD_FRAC_BITS);
      if (r > ctu_pkg::COORD_ONE) r = ctu_pkg::COORD_ONE;
      return r[ctu_pkg::COORD_W-1:0];
   endfunction

   ctu_pkg::ext_type u32, v32;
   logic                        vld_ff;
   logic [ctu_pkg::COORD_W-1:0] u_ff, v_ff;

   assign u32 = ctu_pkg::ext_type'(ang_u) + ctu_pkg::HALF_TURN_EXT;
   assign v32 = ctu_pkg::HALF_TURN_EXT - (ctu_pkg::ext_type'(ang_v) <<< 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= to_coord(u32);
         v_ff <= to_coord(v32);
      end
   end

   assign out_vld = vld_ff;
   assign coord_u = u_ff;
   assign coord_v = v_ff;

endmodule

[rtl/core/cube_texel_to_equirect_uv.sv]
// channel    dir   fields                                   handshake
// req_chan   in    face_index[3] texel_col[12] texel_row[12] valid/ready
// rsp_chan   out   coord_u[17] coord_v[17]                   valid/ready
// csr        in    csr_wdata[13] edge length                csr_we, no wait
//
// One item enters per cycle unless the output stalls; each item passes through
// direction and squares, the one-bit-per-stage square root, the dual-lane
// CORDIC, and rounding into the output register.
// Synchronous reset clears the valid bits and sets the edge length to 512.
// A result held at the output stalls every stage at once; nothing moves or drops.
module cube_texel_to_equirect_uv (
   input  logic                            clock,
   input  logic                            reset,
   ctu_req_if.sink                         req_chan,
   ctu_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [ctu_pkg::EDGE_LEN_W-1:0]  csr_wdata
);

   logic [ctu_pkg::EDGE_LEN_W-1:0]  edge_len_ff;
   logic                            en;

   logic                          dir_vld;
   ctu_pkg::dir_type              dir_val;
   logic [ctu_pkg::SUMSQ_W-1:0]   dir_sumsq;

   logic                          isq_vld;
   logic [ctu_pkg::ROOT_W-1:0]    isq_root;
   ctu_pkg::dir_type              isq_dir;

   ctu_pkg::cvec_type             u_ax, u_ay, v_ax, v_ay;
   logic                          crd_vld;
   ctu_pkg::ang_type              ang_u, ang_v;

   logic                          out_vld;

   // hold face size; to be written only while idle, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_len_ff <= ctu_pkg::EDGE_LEN_RESET;
      end else if (csr_we) begin
         edge_len_ff <= csr_wdata;
      end
   end

   // advance the whole pipe unless a result waits at the output
   assign en             = !out_vld || rsp_chan.ready;
   assign req_chan.ready = en;

   ctu_dir u_dir (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_vld     (req_chan.valid),
      .face_index (req_chan.face_index),
      .texel_col  (req_chan.texel_col),
      .texel_row  (req_chan.texel_row),
      .edge_len   (edge_len_ff),
      .out_vld    (dir_vld),
      .out_dir    (dir_val),
      .out_sumsq  (dir_sumsq)
   );

   ctu_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (dir_vld),
      .in_sumsq (dir_sumsq),
      .in_dir   (dir_val),
      .out_vld  (isq_vld),
      .out_root (isq_root),
      .out_dir  (isq_dir)
   );

   // scale components by 2^16; the root already carries that scale
   assign u_ax = ctu_pkg::cvec_type'(isq_dir.x) <<< ctu_pkg::DIR_SHIFT;
   assign u_ay = ctu_pkg::cvec_type'(isq_dir.z) <<< ctu_pkg::DIR_SHIFT;
   assign v_ax = ctu_pkg::cvec_type'({1'b0, isq_root});
   assign v_ay = ctu_pkg::cvec_type'(isq_dir.y) <<< ctu_pkg::DIR_SHIFT;

   ctu_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (isq_vld),
      .u_ax    (u_ax),
      .u_ay    (u_ay),
      .v_ax    (v_ax),
      .v_ay    (v_ay),
      .out_vld (crd_vld),
      .ang_u   (ang_u),
      .ang_v   (ang_v)
   );

   ctu_coord u_coord (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (crd_vld),
      .ang_u   (ang_u),
      .ang_v   (ang_v),
      .out_vld (out_vld),
      .coord_u (rsp_chan.coord_u),
      .coord_v (rsp_chan.coord_v)
   );

   assign rsp_chan.valid = out_vld;

endmodule

[test/cube_texel_to_equirect_uv_test.sv]
module cube_texel_to_equirect_uv_test;
   timeunit 1ns;
   timeprecision 1ps;

   // pipeline depth, and a drain wait with some margin beyond it
   localparam int PIPE_LATENCY = 62;
   localparam int DRAIN_CYCLES = PIPE_LATENCY + 20;

   typedef struct packed {
      logic [ctu_pkg::COORD_W-1:0] coord_u;
      logic [ctu_pkg::COORD_W-1:0] coord_v;
   } uv_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [ctu_pkg::EDGE_LEN_W-1:0] csr_wdata = '0;

   ctu_req_if req_chan ();
   ctu_rsp_if rsp_chan ();

   cube_texel_to_equirect_uv u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Model-side copy of the edge length register
   logic [ctu_pkg::EDGE_LEN_W-1:0] cur_edge_len = ctu_pkg::EDGE_LEN_RESET;

   uv_item_type uv_expected[$];
   int       fail_count = 0;
   int       send_idle_pct = 26;  // percent of cycles the sender idles
   int       recv_idle_pct = 26;  // percent of cycles the receiver idles
   int       recv_hold = 0;       // cycles of forced back-pressure left

   // atan(2^-i) in 2^-32 turn units
   function automatic longint atan_step(input int i);
      longint tab [0:27] = '{
         536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
         41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
      return tab[i];
   endfunction

   // arithmetic shift right, rounding toward minus infinity
   function automatic longint asr(input longint v, input int sh);
      return v >>> sh;
   endfunction

   function automatic longint vector_angle(input longint ay_in, input longint ax_in);
      longint ax, ay, acc, dx, dy;
      ax = ax_in;
      ay = ay_in;
      acc = 0;
      // fold the left half-plane onto the right one
      if (ax < 0) begin
         acc = (ay >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         ax = -ax;
         ay = -ay;
      end
      for (int i = 0; i < 28; i++) begin
         dx = asr(ay, i);
         dy = asr(ax, i);
         if (ay > 0) begin
            ax += dx;
            ay -= dy;
            acc += atan_step(i);
         end else begin
            ax -= dx;
            ay += dy;
            acc -= atan_step(i);
         end
      end
      return acc;
   endfunction

   function automatic longint int_sqrt(input longint unsigned n_in);
      longint unsigned n, res, b;
      n = n_in;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic logic [ctu_pkg::COORD_W-1:0] turn_to_coord(input longint v32);
      longint r;
      if (v32 < 0) v32 = 0;
      if (v32 > 64'sd4294967296) v32 = 64'sd4294967296;
      r = (v32 + (64'sd1 << (31 - ctu_pkg::COORD_FRAC_BITS)))
          >>> (32 - ctu_pkg::COORD_FRAC_BITS);
      if (r > (64'sd1 << ctu_pkg::COORD_FRAC_BITS)) r = 64'sd1 << ctu_pkg::COORD_FRAC_BITS;
      return r[ctu_pkg::COORD_W-1:0];
   endfunction

   // Map one texel to its equirectangular coordinates
   function automatic uv_item_type texel_to_uv(input logic [ctu_pkg::FACE_IDX_W-1:0] face,
                                              input logic [ctu_pkg::TEXEL_W-1:0] col,
                                              input logic [ctu_pkg::TEXEL_W-1:0] row);
      longint n, a, b, x, y, z, rad, ang_u, ang_v;
      uv_item_type res;
      n = longint'(cur_edge_len);
      a = 2 * longint'(col) + 1 - n;
      b = 2 * longint'(row) + 1 - n;
      // faces six and seven saturate to -Z
      case (face)
         ctu_pkg::FACE_POS_X: begin x = n;  y = -b; z = -a; end
         ctu_pkg::FACE_NEG_X: begin x = -n; y = -b; z = a;  end
         ctu_pkg::FACE_POS_Y: begin x = a;  y = n;  z = b;  end
         ctu_pkg::FACE_NEG_Y: begin x = a;  y = -n; z = -b; end
         ctu_pkg::FACE_POS_Z: begin x = a;  y = -b; z = n;  end
         default:             begin x = -a; y = -b; z = -n; end
      endcase
      x *= 65536;
      y *= 65536;
      z *= 65536;
      ang_u = vector_angle(z, x);
      rad = int_sqrt(longint'(x * x + z * z));
      ang_v = vector_angle(y, rad);
      res.coord_u = turn_to_coord(ang_u + 64'sd2147483648);
      res.coord_v = turn_to_coord(64'sd2147483648 - 2 * ang_v);
      return res;
   endfunction

   // Result side: random back-pressure, with forced holds, and the checker
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (uv_expected.size() == 0) begin
               $error("unexpected result u=%0d v=%0d", rsp_chan.coord_u, rsp_chan.coord_v);
               fail_count++;
            end else begin
               uv_item_type exp_uv;
               exp_uv = uv_expected.pop_front();
               if (rsp_chan.coord_u !== exp_uv.coord_u) begin
                  $error("coord_u expected %0d actual %0d", exp_uv.coord_u, rsp_chan.coord_u);
                  fail_count++;
               end
               if (rsp_chan.coord_v !== exp_uv.coord_v) begin
                  $error("coord_v expected %0d actual %0d", exp_uv.coord_v, rsp_chan.coord_v);
                  fail_count++;
               end
            end
         end
         // hold off while a forced stall is pending
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offer one item; hold it until accepted
   task automatic send_texel(input logic [ctu_pkg::FACE_IDX_W-1:0] face,
                             input logic [ctu_pkg::TEXEL_W-1:0] col,
                             input logic [ctu_pkg::TEXEL_W-1:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.face_index <= face;
      req_chan.texel_col  <= col;
      req_chan.texel_row  <= row;
      do @(posedge clock); while (!req_chan.ready);
      uv_expected.push_back(texel_to_uv(face, col, row));
   endtask

   // Wait for the pipeline to empty, then let its latency pass
   task automatic drain_pipe();
      req_chan.valid <= 1'b0;
      while (uv_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Change edge length only with nothing in flight
   task automatic write_edge_len(input logic [ctu_pkg::EDGE_LEN_W-1:0] size);
      drain_pipe();
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_edge_len = size;
   endtask

   function automatic logic [ctu_pkg::TEXEL_W-1:0] pick_texel(input int limit);
      if (limit <= 0 || $urandom_range(19) == 0) return ctu_pkg::TEXEL_W'($urandom());
      return ctu_pkg::TEXEL_W'($urandom_range(limit - 1));
   endfunction

   // Face centres, corners, poles, seam, out-of-range faces at reset size
   task automatic test_directed();
      for (int f = 0; f < 8; f++) begin
         send_texel(ctu_pkg::FACE_IDX_W'(f), 12'd0, 12'd0);
         send_texel(ctu_pkg::FACE_IDX_W'(f), 12'd511, 12'd511);
      end
      send_texel(ctu_pkg::FACE_POS_Y, 12'd256, 12'd256);  // north pole region
      send_texel(ctu_pkg::FACE_NEG_Y, 12'd255, 12'd255);
      send_texel(ctu_pkg::FACE_NEG_X, 12'd255, 12'd300);  // seam behind the viewer
      send_texel(ctu_pkg::FACE_POS_X, 12'd4095, 12'd4095); // texel outside the face
      send_texel(ctu_pkg::FACE_POS_Z, 12'd2730, 12'd1365);
   endtask

   // Exact poles and seam need odd edge lengths
   task automatic test_poles_and_seam();
      write_edge_len(13'd1);
      for (int f = 0; f < 6; f++) send_texel(ctu_pkg::FACE_IDX_W'(f), 12'd0, 12'd0);
      write_edge_len(13'd0);
      send_texel(ctu_pkg::FACE_NEG_X, 12'd0, 12'd0);
      send_texel(ctu_pkg::FACE_POS_Y, 12'd4095, 12'd0);
      write_edge_len(13'd8191);
      send_texel(ctu_pkg::FACE_NEG_X, 12'd4095, 12'd4095);
      send_texel(ctu_pkg::FACE_POS_Y, 12'd0, 12'd4095);
   endtask

   task automatic random_run(input int count, input int limit);
      for (int i = 0; i < count; i++)
         send_texel(ctu_pkg::FACE_IDX_W'($urandom_range(7)), pick_texel(limit),
                    pick_texel(limit));
   endtask

   // Random texels over several edge lengths, extremes included
   task automatic test_random_sizes();
      int sizes [7] = '{1, 2, 3, 4096, 512, 37, 8191};
      foreach (sizes[k]) begin
         write_edge_len(ctu_pkg::EDGE_LEN_W'(sizes[k]));
         random_run(180, sizes[k] > 4096 ? 4096 : sizes[k]);
      end
      write_edge_len(ctu_pkg::EDGE_LEN_W'($urandom()));
      random_run(150, 4096);
   endtask

   // Full rate both ways, no idling
   task automatic test_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_edge_len(13'd64);
      random_run(250, 64);
      send_idle_pct = 26;
      recv_idle_pct = 26;
   endtask

   // Stall the output long enough to fill the pipe, then pause until empty
   task automatic test_back_pressure();
      write_edge_len(13'd100);
      recv_hold = 3 * PIPE_LATENCY;
      random_run(150, 100);
      drain_pipe();
      random_run(50, 100);
   endtask

   initial begin
      req_chan.valid      <= 1'b0;
      req_chan.face_index <= '0;
      req_chan.texel_col  <= '0;
      req_chan.texel_row  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_poles_and_seam();
      test_random_sizes();
      test_full_rate();
      test_back_pressure();
      drain_pipe();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // generous bound: ~1900 items with random stalls is far below this
   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
